### rtl/core/rtpp_pkg.sv
// Shared types, status codes and defaults for the RTP packet parser.
`timescale 1ns / 1ps
package rtpp_pkg;

	localparam int CSRC_SLOTS_DEF       = 15;
	localparam int MAX_PACKET_BYTES_DEF = 2048;

	localparam logic [7:0] VER_MASK  = 8'hC0;
	localparam logic [7:0] VER_VALUE = 8'h80;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_HDR    = 3'd1;
	localparam logic [2:0] ST_CSRC_SHORT = 3'd2;
	localparam logic [2:0] ST_PHDR_SHORT = 3'd3;
	localparam logic [2:0] ST_LEN_SHORT  = 3'd4;
	localparam logic [2:0] ST_OVERRUN    = 3'd5;
	localparam logic [2:0] ST_TOO_LONG   = 3'd6;

	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic        record_kind;
		logic [2:0]  status;
		logic        marker;
		logic [6:0]  payload_kind;
		logic [15:0] sequence_res;
		logic [31:0] timestamp;
		logic [31:0] source_id;
		logic [3:0]  contributor_count;
		logic [23:0] stream_ident;
		logic [3:0]  frag_and_data_type;
		logic [15:0] last_block_length;
		logic [11:0] consumed_bytes;
	} rec_t;

	// One finished packet: its summary, how many CSRC entries it stored and where
	typedef struct packed {
		rec_t       rec;
		logic [3:0] n_entries;
		logic       bank;
	} summ_t;

endpackage

### rtl/core/rtpp_if.sv
// Byte input and record output channel interfaces.
`timescale 1ns / 1ps
interface rtpp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface rtpp_rec_if;
	logic        valid;
	logic        ready;
	logic        record_kind;
	logic [2:0]  status;
	logic        marker;
	logic [6:0]  payload_kind;
	logic [15:0] sequence_res;
	logic [31:0] timestamp;
	logic [31:0] source_id;
	logic [3:0]  contributor_count;
	logic [23:0] stream_ident;
	logic [3:0]  frag_and_data_type;
	logic [15:0] last_block_length;
	logic [11:0] consumed_bytes;

	modport source(output valid, output record_kind, output status, output marker,
		output payload_kind, output sequence_res, output timestamp, output source_id,
		output contributor_count, output stream_ident, output frag_and_data_type,
		output last_block_length, output consumed_bytes, input ready);
	modport sink(input valid, input record_kind, input status, input marker,
		input payload_kind, input sequence_res, input timestamp, input source_id,
		input contributor_count, input stream_ident, input frag_and_data_type,
		input last_block_length, input consumed_bytes, output ready);
endinterface

### rtl/core/rtpp_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module rtpp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/rtpp_front.sv
// Byte-level header and block walker; builds the packet summary at the last byte.
`timescale 1ns / 1ps
module rtpp_front #(
	parameter int CSRC_SLOTS       = rtpp_pkg::CSRC_SLOTS_DEF,
	parameter int MAX_PACKET_BYTES = rtpp_pkg::MAX_PACKET_BYTES_DEF,
	parameter int RAM_AW           = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	rtpp_byte_if.sink           pkt,
	input  logic                full,
	output logic                push,
	output rtpp_pkg::summ_t     push_data,
	output logic                ram_we,
	output logic [RAM_AW-1:0]   ram_waddr,
	output logic [31:0]         ram_wdata
);

	localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int SLOT_AW = RAM_AW - 1;
	localparam logic [PW-1:0] MAXP = PW'(MAX_PACKET_BYTES);
	localparam logic [3:0] SLOTS4 = 4'(CSRC_SLOTS);

	typedef enum logic [6:0] {
		PH_HDR  = 7'b0000001,
		PH_CSRC = 7'b0000010,
		PH_PHDR = 7'b0000100,
		PH_LEN  = 7'b0001000,
		PH_DATA = 7'b0010000,
		PH_TAIL = 7'b0100000,
		PH_ERR  = 7'b1000000
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [63:0] hdr0_q, hdr0_d;
	logic [31:0] ssrc_q, ssrc_d;
	logic [31:0] phdr_q, phdr_d;
	logic [31:0] ws_q, ws_d;
	logic [1:0]  sub_q, sub_d;
	logic [3:0]  idx_q, idx_d;
	logic [3:0]  nst_q, nst_d;
	logic [3:0]  blk_q, blk_d;
	logic [15:0] skip_q, skip_d;
	logic [2:0]  err_q, err_d;
	logic        hdr_done_q, hdr_done_d;
	logic        phdr_done_q, phdr_done_d;
	logic [15:0] len_q, len_d;
	logic [11:0] cons_q, cons_d;
	logic        bank_q;
	logic        accept;
	logic        fin;
	logic [7:0]  b;
	logic [15:0] len_new;
	logic [2:0]  st;

	assign pkt.ready = !full;
	assign accept    = pkt.valid && pkt.ready;
	assign b         = pkt.data_byte;
	assign len_new   = {ws_q[7:0], b};

	always_comb begin
		ph_d        = ph_q;
		pos_d       = pos_q;
		hdr0_d      = hdr0_q;
		ssrc_d      = ssrc_q;
		phdr_d      = phdr_q;
		ws_d        = ws_q;
		sub_d       = sub_q;
		idx_d       = idx_q;
		nst_d       = nst_q;
		blk_d       = blk_q;
		skip_d      = skip_q;
		err_d       = err_q;
		hdr_done_d  = hdr_done_q;
		phdr_done_d = phdr_done_q;
		len_d       = len_q;
		cons_d      = cons_q;
		fin         = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = {bank_q, idx_q[SLOT_AW-1:0]};
		ram_wdata   = {ws_q[23:0], b};
		if (accept) begin
			if (pos_q >= MAXP) begin
				if (err_q == rtpp_pkg::ST_OK) begin
					err_d = rtpp_pkg::ST_TOO_LONG;
					ph_d  = PH_ERR;
				end
			end else begin
				pos_d = pos_q + 1'b1;
				unique case (ph_q)
					PH_HDR: begin
						if (pos_q == '0 && (b & rtpp_pkg::VER_MASK) != rtpp_pkg::VER_VALUE) begin
							err_d = rtpp_pkg::ST_BAD_HDR;
							ph_d  = PH_ERR;
						end else begin
							if (pos_q < PW'(8)) begin
								hdr0_d[{~pos_q[2:0], 3'b000} +: 8] = b;
							end else if (pos_q < PW'(12)) begin
								ssrc_d[{~pos_q[1:0], 3'b000} +: 8] = b;
							end
							if (pos_q == PW'(11)) begin
								hdr_done_d = 1'b1;
								sub_d      = 2'd0;
								ph_d       = (hdr0_q[59:56] != 4'd0) ? PH_CSRC : PH_PHDR;
							end
						end
					end
					PH_CSRC: begin
						ws_d  = {ws_q[23:0], b};
						sub_d = sub_q + 2'd1;
						if (sub_q == 2'd3) begin
							if (idx_q < SLOTS4) begin
								ram_we = 1'b1;
								nst_d  = idx_q + 4'd1;
							end
							idx_d = idx_q + 4'd1;
							if ({1'b0, idx_q} + 5'd1 >= {1'b0, hdr0_q[59:56]}) begin
								ph_d = PH_PHDR;
							end
						end
					end
					PH_PHDR: begin
						phdr_d = {phdr_q[23:0], b};
						sub_d  = sub_q + 2'd1;
						if (sub_q == 2'd3) begin
							phdr_done_d = 1'b1;
							blk_d       = (b[3:0] != 4'd0) ? b[3:0] : 4'd1;
							ph_d        = PH_LEN;
							ws_d        = '0;
						end
					end
					PH_LEN: begin
						if (sub_q == 2'd0) begin
							ws_d  = {24'd0, b};
							sub_d = 2'd1;
						end else begin
							sub_d  = 2'd0;
							ws_d   = '0;
							len_d  = len_new;
							skip_d = len_new;
							if (len_new == 16'd0) begin
								fin = 1'b1;
							end else begin
								ph_d = PH_DATA;
							end
						end
					end
					PH_DATA: begin
						skip_d = skip_q - 16'd1;
						if (skip_q == 16'd1) begin
							fin = 1'b1;
						end
					end
					PH_TAIL, PH_ERR: begin
					end
					default: begin
					end
				endcase
				if (fin) begin
					blk_d = blk_q - 4'd1;
					if (blk_q == 4'd1) begin
						ph_d   = PH_TAIL;
						cons_d = 12'({1'b0, pos_q} + 1'b1);
					end else begin
						ph_d = PH_LEN;
					end
				end
			end
		end
	end

	// Status as it stands after this byte
	always_comb begin
		if (err_d != rtpp_pkg::ST_OK) begin
			st = err_d;
		end else begin
			unique case (ph_d)
				PH_HDR:  st = rtpp_pkg::ST_BAD_HDR;
				PH_CSRC: st = rtpp_pkg::ST_CSRC_SHORT;
				PH_PHDR: st = rtpp_pkg::ST_PHDR_SHORT;
				PH_LEN:  st = rtpp_pkg::ST_LEN_SHORT;
				PH_DATA: st = rtpp_pkg::ST_OVERRUN;
				default: st = rtpp_pkg::ST_OK;
			endcase
		end
	end

	always_comb begin
		push_data.rec.record_kind        = rtpp_pkg::KIND_SUMMARY;
		push_data.rec.status             = st;
		push_data.rec.marker             = hdr_done_d & hdr0_d[55];
		push_data.rec.payload_kind       = hdr_done_d ? hdr0_d[54:48] : 7'd0;
		push_data.rec.sequence_res       = hdr_done_d ? hdr0_d[47:32] : 16'd0;
		push_data.rec.timestamp          = hdr_done_d ? hdr0_d[31:0] : 32'd0;
		push_data.rec.source_id          = hdr_done_d ? ssrc_d : 32'd0;
		push_data.rec.contributor_count  = hdr_done_d ? hdr0_d[59:56] : 4'd0;
		push_data.rec.stream_ident       = phdr_done_d ? phdr_d[31:8] : 24'd0;
		push_data.rec.frag_and_data_type = phdr_done_d ? {phdr_d[7:6], phdr_d[5:4]} : 4'd0;
		push_data.rec.last_block_length  = len_d;
		push_data.rec.consumed_bytes     = (st == rtpp_pkg::ST_OK) ? cons_d : 12'd0;
		push_data.n_entries              = nst_d;
		push_data.bank                   = bank_q;
	end

	assign push = accept && pkt.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_HDR;
			pos_q       <= '0;
			hdr0_q      <= '0;
			ssrc_q      <= '0;
			phdr_q      <= '0;
			ws_q        <= '0;
			sub_q       <= '0;
			idx_q       <= '0;
			nst_q       <= '0;
			blk_q       <= '0;
			skip_q      <= '0;
			err_q       <= rtpp_pkg::ST_OK;
			hdr_done_q  <= 1'b0;
			phdr_done_q <= 1'b0;
			len_q       <= '0;
			cons_q      <= '0;
			bank_q      <= 1'b0;
		end else if (push) begin
			// packet closed: back to the start state, next packet uses the other bank
			ph_q        <= PH_HDR;
			pos_q       <= '0;
			hdr0_q      <= '0;
			ssrc_q      <= '0;
			phdr_q      <= '0;
			ws_q        <= '0;
			sub_q       <= '0;
			idx_q       <= '0;
			nst_q       <= '0;
			blk_q       <= '0;
			skip_q      <= '0;
			err_q       <= rtpp_pkg::ST_OK;
			hdr_done_q  <= 1'b0;
			phdr_done_q <= 1'b0;
			len_q       <= '0;
			cons_q      <= '0;
			bank_q      <= ~bank_q;
		end else if (accept) begin
			ph_q        <= ph_d;
			pos_q       <= pos_d;
			hdr0_q      <= hdr0_d;
			ssrc_q      <= ssrc_d;
			phdr_q      <= phdr_d;
			ws_q        <= ws_d;
			sub_q       <= sub_d;
			idx_q       <= idx_d;
			nst_q       <= nst_d;
			blk_q       <= blk_d;
			skip_q      <= skip_d;
			err_q       <= err_d;
			hdr_done_q  <= hdr_done_d;
			phdr_done_q <= phdr_done_d;
			len_q       <= len_d;
			cons_q      <= cons_d;
		end
	end

endmodule

### rtl/core/rtpp_queue.sv
// Two-entry queue of finished packet summaries between front and back.
`timescale 1ns / 1ps
module rtpp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rtpp_pkg::summ_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output rtpp_pkg::summ_t head
);

	rtpp_pkg::summ_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### rtl/core/rtpp_back.sv
// Record emitter: CSRC entries read from the RAM bank, then the summary.
`timescale 1ns / 1ps
module rtpp_back #(
	parameter int RAM_AW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  rtpp_pkg::summ_t   head,
	output logic              pop,
	output logic              ram_re,
	output logic [RAM_AW-1:0] ram_raddr,
	input  logic [31:0]       ram_rdata,
	rtpp_rec_if.source        rec
);

	localparam int SLOT_AW = RAM_AW - 1;

	typedef enum logic [2:0] {
		BK_IDLE  = 3'b001,
		BK_ENTRY = 3'b010,
		BK_SUM   = 3'b100
	} bk_state_t;

	bk_state_t      st_q, st_d;
	logic [3:0]     k_q, k_d;
	logic [3:0]     k_nxt;
	logic           out_valid_q;
	rtpp_pkg::rec_t out_q;
	rtpp_pkg::rec_t ent_rec;
	logic           free;
	logic           load_ent;
	logic           load_sum;

	assign free  = !out_valid_q || rec.ready;
	assign k_nxt = k_q + 4'd1;

	always_comb begin
		st_d      = st_q;
		k_d       = k_q;
		ram_re    = 1'b0;
		ram_raddr = {head.bank, {SLOT_AW{1'b0}}};
		pop       = 1'b0;
		load_ent  = 1'b0;
		load_sum  = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (head_valid) begin
					if (head.n_entries != 4'd0) begin
						ram_re = 1'b1;
						k_d    = 4'd0;
						st_d   = BK_ENTRY;
					end else begin
						st_d = BK_SUM;
					end
				end
			end
			BK_ENTRY: begin
				// read data for entry k is waiting; fetch k+1 as it goes out
				if (free) begin
					load_ent = 1'b1;
					if ({1'b0, k_q} + 5'd1 < {1'b0, head.n_entries}) begin
						ram_re    = 1'b1;
						ram_raddr = {head.bank, k_nxt[SLOT_AW-1:0]};
						k_d       = k_nxt;
					end else begin
						st_d = BK_SUM;
					end
				end
			end
			BK_SUM: begin
				if (free) begin
					load_sum = 1'b1;
					pop      = 1'b1;
					st_d     = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		ent_rec                   = head.rec;
		ent_rec.record_kind       = rtpp_pkg::KIND_ENTRY;
		ent_rec.source_id         = ram_rdata;
		ent_rec.contributor_count = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			k_q  <= k_d;
			if (load_ent || load_sum) begin
				out_valid_q <= 1'b1;
			end else if (rec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ent) begin
			out_q <= ent_rec;
		end else if (load_sum) begin
			out_q <= head.rec;
		end
	end

	assign rec.valid              = out_valid_q;
	assign rec.record_kind        = out_q.record_kind;
	assign rec.status             = out_q.status;
	assign rec.marker             = out_q.marker;
	assign rec.payload_kind       = out_q.payload_kind;
	assign rec.sequence_res       = out_q.sequence_res;
	assign rec.timestamp          = out_q.timestamp;
	assign rec.source_id          = out_q.source_id;
	assign rec.contributor_count  = out_q.contributor_count;
	assign rec.stream_ident       = out_q.stream_ident;
	assign rec.frag_and_data_type = out_q.frag_and_data_type;
	assign rec.last_block_length  = out_q.last_block_length;
	assign rec.consumed_bytes     = out_q.consumed_bytes;

endmodule

### rtl/core/rtp_packet_parser.sv
// Throughput: one byte per cycle in, unless the input is stalled;
// one record per cycle out within a packet, unless the output is held.
// The byte input stalls only while two finished packets still wait to be emitted,
// since the CSRC RAM holds two banks, one per outstanding packet.
// Reset clears all parser, queue and emitter control; the CSRC RAM is not cleared
// and is only read at entries written for the packet being emitted.
`timescale 1ns / 1ps
module rtp_packet_parser #(
	parameter int CSRC_SLOTS       = rtpp_pkg::CSRC_SLOTS_DEF,
	parameter int MAX_PACKET_BYTES = rtpp_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rtpp_byte_if.sink  pkt,
	rtpp_rec_if.source rec
);

	localparam int SLOT_AW   = (CSRC_SLOTS > 1) ? $clog2(CSRC_SLOTS) : 1;
	localparam int RAM_AW    = SLOT_AW + 1;
	localparam int RAM_DEPTH = 2 ** RAM_AW;

	logic              full;
	logic              push;
	rtpp_pkg::summ_t   push_data;
	logic              pop;
	logic              head_valid;
	rtpp_pkg::summ_t   head;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic              ram_re;
	logic [RAM_AW-1:0] ram_raddr;
	logic [31:0]       ram_rdata;

	rtpp_front #(
		.CSRC_SLOTS       (CSRC_SLOTS),
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES),
		.RAM_AW           (RAM_AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.full      (full),
		.push      (push),
		.push_data (push_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	rtpp_ram #(
		.WIDTH (32),
		.DEPTH (RAM_DEPTH)
	) u_csrc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rtpp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	rtpp_back #(
		.RAM_AW (RAM_AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.rec        (rec)
	);

endmodule

### rtl/core/rtpp_checker.sv
// Port-level checks on the parser output, bound to the top level.
`timescale 1ns / 1ps
module rtpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rec_valid,
	input logic        rec_ready,
	input logic        rec_record_kind,
	input logic [2:0]  rec_status,
	input logic [31:0] rec_source_id,
	input logic [3:0]  rec_contributor_count,
	input logic [11:0] rec_consumed_bytes
);

	logic [3:0] exp_idx_q;
	logic       rec_acc;

	assign rec_acc = rec_valid && rec_ready;

	// entries seen so far in the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (rec_acc) begin
			if (rec_record_kind == rtpp_pkg::KIND_SUMMARY) begin
				exp_idx_q <= '0;
			end else begin
				exp_idx_q <= exp_idx_q + 4'd1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid && $stable(rec_source_id)
			&& $stable(rec_record_kind) && $stable(rec_status))
		else $error("record changed while stalled");

	a_entry_order: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_record_kind == rtpp_pkg::KIND_ENTRY
			|-> rec_contributor_count == exp_idx_q)
		else $error("CSRC entry index out of sequence");

	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_record_kind == rtpp_pkg::KIND_SUMMARY
			|-> exp_idx_q <= rec_contributor_count)
		else $error("more entries than announced CSRC count");

	a_bad_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_record_kind == rtpp_pkg::KIND_SUMMARY
			&& rec_status == rtpp_pkg::ST_BAD_HDR |-> exp_idx_q == 4'd0)
		else $error("entries emitted for a packet with a bad header");

	a_err_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_status != rtpp_pkg::ST_OK |-> rec_consumed_bytes == 12'd0)
		else $error("consumed count reported on a failed packet");

endmodule

bind rtp_packet_parser rtpp_checker u_rtpp_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.rec_valid             (rec.valid),
	.rec_ready             (rec.ready),
	.rec_record_kind       (rec.record_kind),
	.rec_status            (rec.status),
	.rec_source_id         (rec.source_id),
	.rec_contributor_count (rec.contributor_count),
	.rec_consumed_bytes    (rec.consumed_bytes)
);
